/* rtl/core/acme_pkg.sv */
package acme_pkg;

    localparam logic [3:0] REG_KEY_HIGH = 4'd0;
    localparam logic [3:0] REG_KEY_LOW  = 4'd1;

    typedef struct packed {
        logic load_zero;    // start subkey encryption of zero
        logic load_block;   // start block encryption (chain ^ prepared block)
        logic round;        // advance one round
        logic take_subkeys; // derive K1/K2 from cipher state
        logic take_chain;   // store cipher state as chain value
        logic clear_chain;  // zero chain value
        logic take_mic;     // move the tag bytes into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic final_round;
    } t_dp_status;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] x);
        xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte i of a 128-bit word sits at bits [127-8i -: 8].
    function automatic logic [7:0] get_byte(input logic [127:0] v, input int i);
        get_byte = v[127-8*i -: 8];
    endfunction

    function automatic logic [127:0] next_round_key(input logic [127:0] k,
                                                    input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        next_round_key = {w0, w1, w2, w3};
    endfunction

    function automatic logic [127:0] aes_round(input logic [127:0] s,
                                               input logic [127:0] rk,
                                               input logic mix);
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, all;
        logic [127:0] r;
        r = '0;
        for (int c = 0; c < 4; c++) begin
            for (int j = 0; j < 4; j++) begin
                t[j+4*c] = SBOX[get_byte(s, j + 4*((c+j) & 3))];
            end
        end
        if (mix) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[4*c];
                a1 = t[4*c+1];
                a2 = t[4*c+2];
                a3 = t[4*c+3];
                all = a0 ^ a1 ^ a2 ^ a3;
                t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
                t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
                t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
                t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++) begin
            r[127-8*i -: 8] = t[i];
        end
        aes_round = r ^ rk;
    endfunction

endpackage

/* rtl/core/acme_ctrl.sv */
module acme_ctrl
    import acme_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_last_block,
    output logic       o_valid,
    input  logic       i_stall,
    output t_dp_cmd    o_cmd,
    output logic       o_capture,
    input  t_dp_status i_status
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SUBKEY = 3'd1;
    localparam logic [2:0] ST_START  = 3'd2;
    localparam logic [2:0] ST_BLOCK  = 3'd3;
    localparam logic [2:0] ST_OUT    = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_in_message, n_in_message;
    logic       r_last, n_last;
    logic       r_out_valid, n_out_valid;
    logic       accept;

    assign o_stall = (r_state != ST_IDLE);
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_out_valid;

    always_comb begin
        n_state      = r_state;
        n_in_message = r_in_message;
        n_last       = r_last;
        n_out_valid  = r_out_valid && i_stall;
        o_cmd        = '0;
        o_capture    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_capture = 1'b1;
                    n_last    = i_last_block;
                    if (!r_in_message) begin
                        o_cmd.load_zero = 1'b1;
                        n_state         = ST_SUBKEY;
                    end else begin
                        n_state = ST_START;
                    end
                end
            end
            ST_SUBKEY: begin
                o_cmd.round = 1'b1;
                if (i_status.final_round) begin
                    o_cmd.take_subkeys = 1'b1;
                    o_cmd.clear_chain  = 1'b1;
                    n_in_message       = 1'b1;
                    n_state            = ST_START;
                end
            end
            ST_START: begin
                o_cmd.load_block = 1'b1;
                n_state          = ST_BLOCK;
            end
            ST_BLOCK: begin
                o_cmd.round = 1'b1;
                if (i_status.final_round) begin
                    if (r_last) begin
                        o_cmd.clear_chain = 1'b1;
                        n_in_message      = 1'b0;
                        n_state           = ST_OUT;
                    end else begin
                        o_cmd.take_chain = 1'b1;
                        n_state          = ST_IDLE;
                    end
                end
            end
            ST_OUT: begin
                // hold the tag until the output register is free
                if (!r_out_valid || !i_stall) begin
                    o_cmd.take_mic = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_in_message <= 1'b0;
            r_last       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_in_message <= n_in_message;
            r_last       <= n_last;
            r_out_valid  <= n_out_valid;
        end
    end

endmodule

/* rtl/core/acme_datapath.sv */
module acme_datapath
    import acme_pkg::*;
#(
    parameter int MIC_BYTES = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [63:0]            i_key_high,
    input  logic [63:0]            i_key_low,
    input  logic                   i_capture,
    input  logic [63:0]            i_block_high,
    input  logic [63:0]            i_block_low,
    input  logic [4:0]             i_byte_count,
    input  logic                   i_last_block,
    input  t_dp_cmd                i_cmd,
    output t_dp_status             o_status,
    output logic [8*MIC_BYTES-1:0] o_mic
);

    logic [127:0] r_block;
    logic [4:0]   r_count;
    logic         r_last;
    logic [127:0] r_state;
    logic [127:0] r_rkey;
    logic [7:0]   r_rcon;
    logic [3:0]   r_round;
    logic [127:0] r_chain;
    logic [127:0] r_k1;
    logic [127:0] r_k2;
    logic [8*MIC_BYTES-1:0] r_mic;

    logic [127:0] key, rk_next, round_out, l_dbl, k1_dbl, padded, prepared, mask;
    logic [4:0]   cnt;

    assign key      = {i_key_high, i_key_low};
    assign rk_next  = next_round_key(r_rkey, r_rcon);
    assign round_out = aes_round(r_state, rk_next, r_round != 4'd10);
    assign o_status.final_round = (r_round == 4'd10);

    assign l_dbl  = {round_out[126:0], 1'b0} ^ (round_out[127] ? 128'h87 : 128'h0);
    assign k1_dbl = {l_dbl[126:0], 1'b0} ^ (l_dbl[127] ? 128'h87 : 128'h0);

    // Clamp counts above sixteen, then pad with 0x80 and zeros.
    assign cnt = (r_count > 5'd16) ? 5'd16 : r_count;
    always_comb begin
        mask   = '0;
        padded = '0;
        for (int i = 0; i < 16; i++) begin
            if (5'(i) < cnt) begin
                mask[127-8*i -: 8] = 8'hff;
            end else if (5'(i) == cnt) begin
                padded[127-8*i -: 8] = 8'h80;
            end
        end
        if (!r_last) begin
            prepared = r_block;
        end else if (cnt == 5'd16) begin
            prepared = r_block ^ r_k1;
        end else begin
            prepared = ((r_block & mask) | padded) ^ r_k2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_capture) begin
            r_block <= {i_block_high, i_block_low};
            r_count <= i_byte_count;
            r_last  <= i_last_block;
        end
        if (i_cmd.load_zero || i_cmd.load_block) begin
            r_state <= (i_cmd.load_zero ? 128'h0 : (r_chain ^ prepared)) ^ key;
            r_rkey  <= key;
            r_rcon  <= 8'h01;
            r_round <= 4'd1;
        end else if (i_cmd.round) begin
            r_state <= round_out;
            r_rkey  <= rk_next;
            r_rcon  <= xtime(r_rcon);
            r_round <= r_round + 4'd1;
        end
        if (i_cmd.take_subkeys) begin
            r_k1 <= l_dbl;
            r_k2 <= k1_dbl;
        end
        if (i_cmd.take_mic) begin
            r_mic <= r_state[127 -: 8*MIC_BYTES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= '0;
        end else if (i_cmd.clear_chain) begin
            r_chain <= '0;
        end else if (i_cmd.take_chain) begin
            r_chain <= round_out;
        end
    end

    assign o_mic = r_mic;

endmodule

/* rtl/core/aes_cmac_mic_engine.sv */
// AES-128 CMAC engine returning the leading MIC_BYTES tag bytes as the MIC.
// One block is taken at a time: a block goes through capture, chain load and
// ten rounds on one shared round unit with on-the-fly key expansion, and the
// first block of a message adds the zero-block encryption that yields the
// subkeys. A last block then moves its MIC into the output register, which
// holds it until taken; the next message can start meanwhile, and a later last
// block waits for that register to free up. Non-last blocks produce no result.
// Keys are to be written only while idle; the block itself does not enforce it.
module aes_cmac_mic_engine
    import acme_pkg::*;
#(
    parameter int MIC_BYTES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_block_high,
    input  logic [63:0] i_block_low,
    input  logic [4:0]  i_byte_count,
    input  logic        i_last_block,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_mic
);

    logic [63:0]            r_key_high, r_key_low;
    t_dp_cmd                cmd;
    t_dp_status             status;
    logic                   capture;
    logic [8*MIC_BYTES-1:0] mic;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_KEY_HIGH) begin
                r_key_high <= i_cfg_data;
            end
            if (i_cfg_index == REG_KEY_LOW) begin
                r_key_low <= i_cfg_data;
            end
        end
    end

    acme_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_last_block (i_last_block),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_cmd        (cmd),
        .o_capture    (capture),
        .i_status     (status)
    );

    acme_datapath #(.MIC_BYTES(MIC_BYTES)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_key_high   (r_key_high),
        .i_key_low    (r_key_low),
        .i_capture    (capture),
        .i_block_high (i_block_high),
        .i_block_low  (i_block_low),
        .i_byte_count (i_byte_count),
        .i_last_block (i_last_block),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_mic        (mic)
    );

    assign o_mic = 32'(mic);

endmodule

/* sim/aes_cmac_mic_engine_tb.sv */
`timescale 1ns / 1ps

module aes_cmac_mic_engine_tb;
    import acme_pkg::*;

    class mic_scoreboard;
        bit [63:0]   key_hi, key_lo;
        bit [127:0]  chain, k1, k2;
        bit          mid_msg;
        bit [31:0]   mic_q[$];
        int          errors;

        function new();
            key_hi = '0; key_lo = '0; chain = '0; k1 = '0; k2 = '0;
            mid_msg = 0; errors = 0;
        endfunction

        function automatic bit [7:0] mul2(bit [7:0] x);
            return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
        endfunction

        function automatic bit [127:0] encrypt(bit [127:0] pt);
            bit [127:0] rk, s, t;
            bit [31:0]  w3, sub;
            bit [7:0]   rc, a0, a1, a2, a3, x;
            rk = {key_hi, key_lo};
            s = pt ^ rk;
            rc = 8'h01;
            for (int r = 1; r <= 10; r++) begin
                w3 = rk[31:0];
                sub = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]],
                       SBOX[w3[31:24]]};
                rk[127:96] = rk[127:96] ^ sub;
                rk[95:64]  = rk[95:64] ^ rk[127:96];
                rk[63:32]  = rk[63:32] ^ rk[95:64];
                rk[31:0]   = rk[31:0] ^ rk[63:32];
                rc = mul2(rc);
                // substitute and shift rows
                for (int c = 0; c < 4; c++)
                    for (int j = 0; j < 4; j++)
                        t[127-8*(j+4*c) -: 8] = SBOX[s[127-8*(j+4*((c+j)&3)) -: 8]];
                if (r < 10) begin
                    for (int c = 0; c < 4; c++) begin
                        a0 = t[127-32*c -: 8];
                        a1 = t[119-32*c -: 8];
                        a2 = t[111-32*c -: 8];
                        a3 = t[103-32*c -: 8];
                        x = a0 ^ a1 ^ a2 ^ a3;
                        t[127-32*c -: 8] = a0 ^ x ^ mul2(a0 ^ a1);
                        t[119-32*c -: 8] = a1 ^ x ^ mul2(a1 ^ a2);
                        t[111-32*c -: 8] = a2 ^ x ^ mul2(a2 ^ a3);
                        t[103-32*c -: 8] = a3 ^ x ^ mul2(a3 ^ a0);
                    end
                end
                s = t ^ rk;
            end
            return s;
        endfunction

        function automatic bit [127:0] dbl(bit [127:0] v);
            return {v[126:0], 1'b0} ^ (v[127] ? 128'h87 : 128'h0);
        endfunction

        function void write_key(bit [3:0] idx, bit [63:0] val);
            if (idx == REG_KEY_HIGH) key_hi = val;
            else if (idx == REG_KEY_LOW) key_lo = val;
        endfunction

        function void note_block(bit [63:0] bh, bit [63:0] bl, bit [4:0] cnt,
                                 bit last);
            bit [127:0] blk, tag;
            int n;
            blk = {bh, bl};
            if (!mid_msg) begin
                k1 = dbl(encrypt('0));
                k2 = dbl(k1);
                chain = '0;
                mid_msg = 1;
            end
            if (!last) begin
                chain = encrypt(chain ^ blk);
                return;
            end
            n = (cnt > 16) ? 16 : cnt;
            if (n == 16) begin
                blk ^= k1;
            end else begin
                // pad: keep n bytes, then 0x80, then zeros
                for (int i = n; i < 16; i++) blk[127-8*i -: 8] = 8'h00;
                blk[127-8*n -: 8] = 8'h80;
                blk ^= k2;
            end
            tag = encrypt(chain ^ blk);
            mic_q.push_back(tag[127:96]);
            chain = '0;
            mid_msg = 0;
        endfunction

        function void check_mic(bit [31:0] got);
            bit [31:0] exp_mic;
            if (mic_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected mic %h", got);
                return;
            end
            exp_mic = mic_q.pop_front();
            if (exp_mic !== got) begin
                errors++;
                if (errors <= 10) $display("mic mismatch: exp %h got %h", exp_mic, got);
            end
        endfunction
    endclass

    logic        i_clk, i_rst_n, i_cfg_we, i_valid, i_last_block, i_stall;
    logic [3:0]  i_cfg_index;
    logic [63:0] i_cfg_data, i_block_high, i_block_low;
    logic [4:0]  i_byte_count;
    logic        o_stall, o_valid;
    logic [31:0] o_mic;

    mic_scoreboard sb;
    bit            no_idle;
    int            blocks_sent;

    aes_cmac_mic_engine DUT (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic write_key(bit [3:0] idx, bit [63:0] val);
        i_cfg_we <= 1; i_cfg_index <= idx; i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 0;
        sb.write_key(idx, val);
        @(negedge i_clk);
    endtask

    // valid stays high after acceptance until the next request or an idle cycle
    task automatic send_block(bit [63:0] bh, bit [63:0] bl, bit [4:0] cnt, bit last);
        while (!no_idle && $urandom_range(99) < 30) begin
            i_valid <= 0;
            @(negedge i_clk);
        end
        i_valid <= 1; i_block_high <= bh; i_block_low <= bl;
        i_byte_count <= cnt; i_last_block <= last;
        forever begin
            @(posedge i_clk);
            if (!o_stall) break;
        end
        sb.note_block(bh, bl, cnt, last);
        blocks_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        i_valid <= 0;
        while (sb.mic_q.size() != 0 && guard < 200000) begin
            @(negedge i_clk);
            guard++;
        end
        // a trailing non-last block may still be in the round unit
        repeat (30) @(negedge i_clk);
    endtask

    function automatic bit [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    task automatic random_message(int max_len);
        int len;
        bit [4:0] cnt;
        len = $urandom_range(max_len);
        for (int i = 0; i < len; i++) begin
            // mostly full blocks; a short count on a non-last block is ignored
            cnt = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'd16;
            send_block(rnd64(), rnd64(), cnt, 0);
        end
        cnt = ($urandom_range(3) == 0) ? 5'($urandom_range(16, 31)) :
                                        5'($urandom_range(16));
        send_block(rnd64(), rnd64(), cnt, 1);
    endtask

    // accept results; stall at random except in the quiet window
    always @(negedge i_clk) begin
        if (!i_rst_n) i_stall <= 0;
        else i_stall <= !no_idle && ($urandom_range(99) < 30);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_mic(o_mic);
    end

    initial begin
        sb = new();
        i_rst_n = 0; i_cfg_we = 0; i_cfg_index = '0; i_cfg_data = '0;
        i_valid = 0; i_block_high = '0; i_block_low = '0;
        i_byte_count = '0; i_last_block = 0;
        no_idle = 0; blocks_sent = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: zero key, then the RFC 4493 example key
        send_block('0, '0, 5'd0, 1);
        drain();
        write_key(REG_KEY_HIGH, 64'h2b7e151628aed2a6);
        write_key(REG_KEY_LOW, 64'habf7158809cf4f3c);
        send_block('0, '0, 5'd0, 1);
        send_block(64'h6bc1bee22e409f96, 64'he93d7e117393172a, 5'd16, 1);
        send_block(64'h6bc1bee22e409f96, 64'he93d7e117393172a, 5'd16, 0);
        send_block(64'hae2d8a571e03ac9c, 64'h9eb76fac45af8e51, 5'd4, 1);
        send_block('1, '1, 5'd15, 1);
        send_block('1, '1, 5'd31, 1);
        send_block('1, '1, 5'd17, 1);
        send_block('1, '1, 5'd1, 1);
        send_block('1, '1, 5'd7, 0);
        send_block('0, '1, 5'd8, 1);
        send_block('1, '0, 5'd0, 0);
        send_block('1, '0, 5'd9, 1);
        drain();
        write_key(REG_KEY_HIGH, '1);
        write_key(REG_KEY_LOW, '1);
        send_block('1, '1, 5'd16, 0);
        send_block('1, '1, 5'd16, 1);
        drain();
        write_key(REG_KEY_HIGH, '0);
        send_block('0, '1, 5'd16, 1);

        // random phases with new keys between them
        for (int ph = 0; ph < 8; ph++) begin
            drain();
            write_key(REG_KEY_HIGH, rnd64());
            write_key(REG_KEY_LOW, rnd64());
            no_idle = (ph == 3);
            for (int m = 0; m < 37; m++) random_message(5);
        end
        no_idle = 0;
        drain();
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
